>>> sv/serial_frame_receiver_core_macros.svh
`ifndef SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SFRC_ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SFRC_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> sv/sfrc_pkg.sv
package sfrc_pkg;

  localparam int MAX_FRAME_DEFAULT = 1024;

  localparam logic [7:0] SYNC_VALUE_RESET   = 8'd2;
  localparam logic [7:0] END_VALUE_RESET    = 8'd3;
  localparam logic [9:0] MAX_BODY_LEN_RESET = 10'd1021;
  localparam int         INDEX_CAP          = 1021;

  localparam logic [1:0] REG_SYNC_VALUE   = 2'd0;
  localparam logic [1:0] REG_END_VALUE    = 2'd1;
  localparam logic [1:0] REG_MAX_BODY_LEN = 2'd2;

  localparam logic [2:0] STATUS_BUSY  = 3'd0;
  localparam logic [2:0] STATUS_GOOD  = 3'd1;
  localparam logic [2:0] STATUS_CHECK = 3'd2;
  localparam logic [2:0] STATUS_END   = 3'd3;
  localparam logic [2:0] STATUS_LEN   = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic        last;
    logic [2:0]  status;
    logic [10:0] frame_length;
  } result_t;

endpackage

>>> sv/serial_frame_receiver_core.sv
// Serial frame receiver. Takes one received byte per transfer and hunts for the sync
// byte; the frame then carries a 16-bit big-endian body length and the body, whose last
// two bytes are the check byte (inverted XOR of all earlier frame bytes) and the end
// marker. Each frame byte leaves as one transfer with its index; the final byte carries
// last, a status and the total frame length. Bytes outside a frame produce nothing. The
// block takes one byte per clock: each byte passes a compare and an XOR update into a
// result register backed by a one-entry skid register, so a stalled output costs no
// input cycle until both are full. Configuration writes are always ready and should be
// made while no frame is in flight.
module serial_frame_receiver_core #(
  parameter int MAX_FRAME = sfrc_pkg::MAX_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [9:0]  byte_index,
  output logic        last,
  output logic [2:0]  status,
  output logic [10:0] frame_length
);

`include "serial_frame_receiver_core_macros.svh"

  localparam int         CAP_INT  = (MAX_FRAME - 3 < sfrc_pkg::INDEX_CAP) ?
                                    (MAX_FRAME - 3) : sfrc_pkg::INDEX_CAP;
  localparam logic [9:0] BODY_CAP = 10'(CAP_INT);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  logic [7:0] sync_value;
  logic [7:0] end_value;
  logic [9:0] max_body_len;

  phase_t     phase, phase_next;
  logic [7:0] len_hi, len_hi_next;
  logic [9:0] body_last, body_last_next;
  logic [9:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic       check_failed, check_failed_next;

  sfrc_pkg::result_t out_res;
  sfrc_pkg::result_t skid_res;
  sfrc_pkg::result_t res;
  logic              skid_valid;
  logic              emit;

  logic        in_fire;
  logic        out_fire;
  logic [9:0]  body_limit;
  logic [15:0] len_full;
  logic [9:0]  check_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !skid_valid;
  assign out_fire  = out_valid && !out_stall;

  assign body_limit = (max_body_len > BODY_CAP) ? BODY_CAP : max_body_len;
  assign len_full   = {len_hi, rx_byte};
  assign check_idx  = body_last - 10'd1;

  always_comb begin
    phase_next        = phase;
    len_hi_next       = len_hi;
    body_last_next    = body_last;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor ^ rx_byte;
    check_failed_next = check_failed;
    emit              = 1'b1;
    res.data_byte     = rx_byte;
    res.byte_index    = byte_count;
    res.last          = 1'b0;
    res.status        = sfrc_pkg::STATUS_BUSY;
    res.frame_length  = 11'd0;
    case (phase)
      PH_HUNT: begin
        emit              = (rx_byte == sync_value);
        running_xor_next  = rx_byte;
        check_failed_next = 1'b0;
        byte_count_next   = 10'd1;
        res.byte_index    = 10'd0;
        if (emit) begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_next     = rx_byte;
        byte_count_next = 10'd2;
        res.byte_index  = 10'd1;
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res.byte_index = 10'd2;
        if (len_full < 16'd2 || len_full > {6'd0, body_limit}) begin
          phase_next       = PH_HUNT;
          byte_count_next  = 10'd0;
          res.last         = 1'b1;
          res.status       = sfrc_pkg::STATUS_LEN;
          res.frame_length = 11'd3;
        end else begin
          body_last_next  = len_full[9:0] + 10'd2;
          byte_count_next = 10'd3;
          phase_next      = PH_BODY;
        end
      end
      PH_BODY: begin
        if (byte_count < check_idx) begin
          byte_count_next = byte_count + 10'd1;
        end else if (byte_count == check_idx) begin
          check_failed_next = (rx_byte != ~running_xor);
          byte_count_next   = byte_count + 10'd1;
        end else begin
          phase_next       = PH_HUNT;
          byte_count_next  = 10'd0;
          res.last         = 1'b1;
          res.frame_length = {1'b0, byte_count} + 11'd1;
          if (check_failed) begin
            res.status = sfrc_pkg::STATUS_CHECK;
          end else if (rx_byte != end_value) begin
            res.status = sfrc_pkg::STATUS_END;
          end else begin
            res.status = sfrc_pkg::STATUS_GOOD;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        emit       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value   <= sfrc_pkg::SYNC_VALUE_RESET;
      end_value    <= sfrc_pkg::END_VALUE_RESET;
      max_body_len <= sfrc_pkg::MAX_BODY_LEN_RESET;
      phase        <= PH_HUNT;
      len_hi       <= 8'd0;
      body_last    <= 10'd0;
      byte_count   <= 10'd0;
      running_xor  <= 8'd0;
      check_failed <= 1'b0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfrc_pkg::REG_SYNC_VALUE:   sync_value   <= cfg_data[7:0];
          sfrc_pkg::REG_END_VALUE:    end_value    <= cfg_data[7:0];
          sfrc_pkg::REG_MAX_BODY_LEN: max_body_len <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase        <= phase_next;
        len_hi       <= len_hi_next;
        body_last    <= body_last_next;
        byte_count   <= byte_count_next;
        running_xor  <= running_xor_next;
        check_failed <= check_failed_next;
      end
      // skid is only full while input is stalled
      if (out_fire) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else if (in_fire && emit) begin
          out_res <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_fire && emit) begin
        if (!out_valid) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign data_byte    = out_res.data_byte;
  assign byte_index   = out_res.byte_index;
  assign last         = out_res.last;
  assign status       = out_res.status;
  assign frame_length = out_res.frame_length;

  `SFRC_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `SFRC_ASSERT_IMPL(a_last_has_status, out_valid && last,
                    status != sfrc_pkg::STATUS_BUSY, "final byte without status")
  `SFRC_ASSERT_IMPL(a_busy_no_length, out_valid && !last,
                    status == sfrc_pkg::STATUS_BUSY && frame_length == 11'd0,
                    "non-final byte with status or length")
  `SFRC_ASSERT_IMPL(a_body_index_range, phase == PH_BODY,
                    byte_count >= 10'd3 && byte_count <= body_last,
                    "body index outside frame")
  `SFRC_ASSERT_NEXT(a_drop_in_hunt, in_fire && phase == PH_HUNT && rx_byte != sync_value,
                    phase == PH_HUNT, "left hunt without sync")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAME_CAP = sfrc_pkg::MAX_FRAME_DEFAULT;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY} rx_phase_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_byte;
  logic [9:0]  byte_index;
  logic        last;
  logic [2:0]  status;
  logic [10:0] frame_length;

  serial_frame_receiver_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .last(last),
    .status(status),
    .frame_length(frame_length)
  );

  logic [7:0] cur_sync;
  logic [7:0] cur_end;
  logic [9:0] cur_max_body;

  rx_phase_t  rx_phase;
  logic [15:0] body_len;
  logic [9:0] pos;
  logic [7:0] run_xor;
  logic       check_bad;

  sfrc_pkg::result_t outgoing[$];
  int  mismatches;
  int  produced;
  int  cycles;
  bit  quiet;
  int  stall_left;
  int  run_left;

  initial begin
    clk = 0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned body_limit();
    int unsigned lim;
    lim = cur_max_body;
    if (lim > FRAME_CAP - 3) lim = FRAME_CAP - 3;
    if (lim > sfrc_pkg::INDEX_CAP) lim = sfrc_pkg::INDEX_CAP;
    return lim;
  endfunction

  function automatic bit frame_byte_from_rx(logic [7:0] b);
    sfrc_pkg::result_t r;
    int unsigned total;
    r = '0;
    r.data_byte = b;
    r.status = sfrc_pkg::STATUS_BUSY;
    case (rx_phase)
      PH_HUNT: begin
        if (b != cur_sync) return 0;
        run_xor = b;
        check_bad = 0;
        body_len = '0;
        pos = 10'd1;
        rx_phase = PH_LEN_HI;
        r.byte_index = 10'd0;
      end
      PH_LEN_HI: begin
        run_xor ^= b;
        body_len = {b, 8'h00};
        pos = 10'd2;
        rx_phase = PH_LEN_LO;
        r.byte_index = 10'd1;
      end
      PH_LEN_LO: begin
        run_xor ^= b;
        body_len[7:0] = b;
        r.byte_index = 10'd2;
        if (body_len < 2 || body_len > body_limit()) begin
          rx_phase = PH_HUNT;
          pos = '0;
          r.last = 1'b1;
          r.status = sfrc_pkg::STATUS_LEN;
          r.frame_length = 11'd3;
        end else begin
          pos = 10'd3;
          rx_phase = PH_BODY;
        end
      end
      default: begin
        total = body_len + 3;
        r.byte_index = pos;
        if (pos + 2 < total) begin
          run_xor ^= b;
          pos = pos + 1'b1;
        end else if (pos + 2 == total) begin
          check_bad = (b != ~run_xor);
          run_xor ^= b;
          pos = pos + 1'b1;
        end else begin
          r.last = 1'b1;
          if (check_bad) r.status = sfrc_pkg::STATUS_CHECK;
          else if (b != cur_end) r.status = sfrc_pkg::STATUS_END;
          else r.status = sfrc_pkg::STATUS_GOOD;
          r.frame_length = total[10:0];
          rx_phase = PH_HUNT;
          pos = '0;
        end
      end
    endcase
    outgoing.push_back(r);
    return 1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    sfrc_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outgoing.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual byte %0h index %0d",
                 $time, data_byte, byte_index);
        mismatches++;
      end else begin
        want = outgoing.pop_front();
        check_field("data_byte", want.data_byte, data_byte);
        check_field("byte_index", want.byte_index, byte_index);
        check_field("last", want.last, last);
        check_field("status", want.status, status);
        check_field("frame_length", want.frame_length, frame_length);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d transfers outstanding", $time, outgoing.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (quiet) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall = 1'b0;
      run_left--;
    end else begin
      out_stall = 1'b0;
      case ($urandom_range(0, 3))
        0: run_left = $urandom_range(20, 60);
        1: run_left = $urandom_range(1, 11);
        default: stall_left = $urandom_range(1, 11);
      endcase
    end
  end

  task automatic send_rx(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (in_stall);
    if (frame_byte_from_rx(b)) produced++;
  endtask

  task automatic stop_rx();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (outgoing.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Finish any open frame, then wait for the block to go quiet.
  task automatic settle();
    while (rx_phase != PH_HUNT) send_rx(cur_end);
    stop_rx();
    drain();
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfrc_pkg::REG_SYNC_VALUE: cur_sync = value[7:0];
      sfrc_pkg::REG_END_VALUE: cur_end = value[7:0];
      sfrc_pkg::REG_MAX_BODY_LEN: cur_max_body = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] len, input bit bad_check, input bit bad_end,
                            input int cut_at);
    logic [7:0] frame[$];
    logic [7:0] x;
    int sent;
    frame = {};
    frame.push_back(cur_sync);
    frame.push_back(len[15:8]);
    frame.push_back(len[7:0]);
    if (len >= 2 && len <= body_limit()) begin
      for (int i = 0; i < len - 2; i++) frame.push_back(8'($urandom));
      x = '0;
      foreach (frame[i]) x ^= frame[i];
      x = ~x;
      if (bad_check) x ^= 8'($urandom_range(1, 255));
      frame.push_back(x);
      frame.push_back(bad_end ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end);
    end
    sent = 0;
    foreach (frame[i]) begin
      if (cut_at >= 0 && sent >= cut_at) break;
      send_rx(frame[i]);
      sent++;
    end
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (b == cur_sync) b = ~b;
      send_rx(b);
    end
  endtask

  task automatic test_directed();
    send_noise(1);
    send_frame(16'd2, 0, 0, -1);
    send_frame(16'd4, 1, 0, -1);
    send_frame(16'd2, 0, 1, -1);
    send_frame(16'd2, 1, 1, -1);
    send_frame(16'hFFFF, 0, 0, -1);
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(sfrc_pkg::REG_SYNC_VALUE, 10'h300);
    write_reg(sfrc_pkg::REG_END_VALUE, 10'h0FF);
    write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'd2);
    send_frame(16'd2, 0, 0, -1);
    send_frame(16'd3, 0, 0, -1);
    send_frame(16'd0, 0, 0, -1);
    send_frame(16'd1, 0, 0, -1);
    settle();
    write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'd0);
    send_frame(16'd2, 0, 0, -1);
    settle();
    write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'd1);
    write_reg(REG_UNUSED, 10'h3FF);
    send_frame(16'd2, 0, 0, -1);
    send_frame(16'd1, 0, 0, -1);
    settle();
    write_reg(sfrc_pkg::REG_SYNC_VALUE, 10'h0FF);
    write_reg(sfrc_pkg::REG_END_VALUE, 10'h200);
    write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'h3FF);
    send_frame(16'd1021, 0, 0, -1);
    send_frame(16'd1022, 0, 0, -1);
    settle();
    write_reg(sfrc_pkg::REG_SYNC_VALUE, 10'(sfrc_pkg::SYNC_VALUE_RESET));
    write_reg(sfrc_pkg::REG_END_VALUE, 10'(sfrc_pkg::END_VALUE_RESET));
    write_reg(sfrc_pkg::REG_MAX_BODY_LEN, sfrc_pkg::MAX_BODY_LEN_RESET);
    send_frame(16'd6, 1, 1, -1);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned lim;
    int unsigned pick;
    logic [15:0] len;
    int next_cfg;
    int cut;
    produced = 0;
    next_cfg = 100;
    while (produced < RANDOM_ITEMS) begin
      if (produced >= next_cfg) begin
        settle();
        write_reg(sfrc_pkg::REG_SYNC_VALUE, 10'($urandom));
        write_reg(sfrc_pkg::REG_END_VALUE, 10'($urandom));
        if ($urandom_range(0, 7) == 0) begin
          write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'($urandom_range(0, 1)));
        end else begin
          write_reg(sfrc_pkg::REG_MAX_BODY_LEN, 10'($urandom_range(2, 1023)));
        end
        next_cfg += 100;
      end
      if (produced > RANDOM_ITEMS - 150) quiet = 1;
      lim = body_limit();
      pick = $urandom_range(0, 99);
      if (lim < 2 || pick < 6) len = 16'($urandom_range(0, 1));
      else if (pick < 12) len = 16'($urandom_range(lim + 1, 65535));
      else if (pick < 13) len = 16'($urandom_range(2, lim));
      else len = 16'($urandom_range(2, (lim < 24) ? lim : 24));
      cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 6) : -1;
      send_frame(len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, cut);
      send_noise($urandom_range(0, 2));
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
    quiet = 0;
    stall_left = 0;
    run_left = 0;
    mismatches = 0;
    produced = 0;
    cycles = 0;
    cur_sync = sfrc_pkg::SYNC_VALUE_RESET;
    cur_end = sfrc_pkg::END_VALUE_RESET;
    cur_max_body = sfrc_pkg::MAX_BODY_LEN_RESET;
    rx_phase = PH_HUNT;
    body_len = '0;
    pos = '0;
    run_xor = '0;
    check_bad = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_extremes();
    test_random_frames();

    drain();
    repeat (20) @(posedge clk);
    if (outgoing.size() != 0) begin
      $display("%0t %0d transfers expected, none arrived", $time, outgoing.size());
      mismatches++;
    end
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
